FILE: rtl/core/double_ended_queue_core_assert.svh
// Assertion macros for the double-ended queue core.
// Used by the port-level checker; no other dependencies.
`ifndef DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication under reset.
`define DEQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under reset.
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/deq_pkg.sv
// Shared types and constants for the double-ended queue core.
// No dependencies.
`default_nettype none
package deq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int OP_W           = 3;
    localparam int VALUE_W        = 32;
    localparam int STATUS_W       = 2;
    localparam int ITEM_W         = 32;

    localparam logic [OP_W-1:0] OP_DISPLAY    = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic signed [VALUE_W-1:0] value;
    } deq_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [ITEM_W-1:0] item;
        logic                     last;
    } deq_rsp_t;

endpackage
`default_nettype wire

FILE: rtl/core/deq_store.sv
// Slot memory of the double-ended queue: one write port, one registered read port.
// Depends on nothing but its parameters.
`default_nettype none
module deq_store #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]      wr_addr,
    input  wire logic [DATA_WIDTH-1:0]         wr_data,
    input  wire logic                          rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]      rd_addr,
    output logic      [DATA_WIDTH-1:0]         rd_data
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/double_ended_queue_core.sv
// Push and pop: one word per cycle unless the output stalls; result valid in the
// cycle after acceptance. Display: first word via the memory read register and
// the result register, then one per cycle unless stalled; busy until last word.
// Reset (rst_n, async low) empties the queue and drops any pending result;
// slot contents are unknown until written.
`default_nettype none
module double_ended_queue_core #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    output logic                   cmd_ready,
    input  wire deq_pkg::deq_cmd_t cmd,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output deq_pkg::deq_rsp_t      rsp
);

    import deq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DISP = 2'b10
    } state_t;

    state_t               state_reg, state_next;
    logic [PTR_W-1:0]     front_reg, front_next;
    logic [CNT_W-1:0]     occ_reg, occ_next;
    logic [CNT_W-1:0]     disp_cnt_reg, disp_cnt_next;
    logic [PTR_W-1:0]     disp_addr_reg, disp_addr_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    deq_rsp_t             rsp_reg, rsp_next;

    logic                 cmd_fire;
    logic                 out_free;
    logic                 is_full;
    logic                 is_empty;
    logic [PTR_W-1:0]     front_dec;
    logic [PTR_W-1:0]     front_inc;
    logic [SUM_W-1:0]     back_sum;
    logic [PTR_W-1:0]     back_addr;
    logic [PTR_W-1:0]     disp_inc;
    logic                 disp_last;
    logic [VALUE_W-1:0]   value_bits;

    logic                 wr_en;
    logic [PTR_W-1:0]     wr_addr;
    logic                 rd_en;
    logic [PTR_W-1:0]     rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;

    deq_store #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (DATA_WIDTH'(value_bits)),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign value_bits = cmd.value;
    assign out_free   = !rsp_valid_reg || rsp_ready;
    assign cmd_ready  = (state_reg == S_IDLE) && out_free;
    assign cmd_fire   = cmd_valid && cmd_ready;
    assign is_full    = (occ_reg == CNT_W'(DEPTH));
    assign is_empty   = (occ_reg == '0);
    assign front_dec  = (front_reg == '0) ? PTR_W'(DEPTH - 1) : front_reg - PTR_W'(1);
    assign front_inc  = (front_reg == PTR_W'(DEPTH - 1)) ? '0 : front_reg + PTR_W'(1);
    assign back_sum   = SUM_W'(front_reg) + SUM_W'(occ_reg);
    assign back_addr  = (back_sum >= SUM_W'(DEPTH)) ? PTR_W'(back_sum - SUM_W'(DEPTH))
                                                    : PTR_W'(back_sum);
    assign disp_inc   = (disp_addr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                             : disp_addr_reg + PTR_W'(1);
    assign disp_last  = (CNT_W'(disp_cnt_reg + CNT_W'(1)) == occ_reg);
    assign rd_addr    = (state_reg == S_IDLE) ? front_reg : disp_inc;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        front_next     = front_reg;
        occ_next       = occ_reg;
        disp_cnt_next  = disp_cnt_reg;
        disp_addr_next = disp_addr_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        wr_en          = 1'b0;
        wr_addr        = back_addr;
        rd_en          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    rsp_next.item = '0;
                    rsp_next.last = 1'b1;
                    unique case (cmd.op)
                        OP_DISPLAY:
                        begin
                            if (is_empty)
                            begin
                                rsp_valid_next  = 1'b1;
                                rsp_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                rd_en          = 1'b1;
                                disp_addr_next = front_reg;
                                disp_cnt_next  = '0;
                                state_next     = S_DISP;
                            end
                        end
                        OP_PUSH_FRONT:
                        begin
                            rsp_valid_next = 1'b1;
                            if (is_full)
                            begin
                                rsp_next.status = ST_FULL;
                            end
                            else
                            begin
                                wr_en           = 1'b1;
                                wr_addr         = front_dec;
                                front_next      = front_dec;
                                occ_next        = occ_reg + CNT_W'(1);
                                rsp_next.status = ST_OK;
                            end
                        end
                        OP_PUSH_BACK:
                        begin
                            rsp_valid_next = 1'b1;
                            if (is_full)
                            begin
                                rsp_next.status = ST_FULL;
                            end
                            else
                            begin
                                wr_en           = 1'b1;
                                occ_next        = occ_reg + CNT_W'(1);
                                rsp_next.status = ST_OK;
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            rsp_valid_next = 1'b1;
                            if (is_empty)
                            begin
                                rsp_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                front_next      = front_inc;
                                occ_next        = occ_reg - CNT_W'(1);
                                rsp_next.status = ST_OK;
                            end
                        end
                        OP_POP_BACK:
                        begin
                            rsp_valid_next = 1'b1;
                            if (is_empty)
                            begin
                                rsp_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                occ_next        = occ_reg - CNT_W'(1);
                                rsp_next.status = ST_OK;
                            end
                        end
                        default:
                        begin
                            rsp_next = rsp_reg;
                        end
                    endcase
                end
            end
            S_DISP:
            begin
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_next.status = ST_OK;
                    rsp_next.item   = ITEM_W'(rd_data);
                    rsp_next.last   = disp_last;
                    if (disp_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_en          = 1'b1;
                        disp_addr_next = disp_inc;
                        disp_cnt_next  = disp_cnt_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            occ_reg       <= '0;
            disp_cnt_reg  <= '0;
            disp_addr_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            occ_reg       <= occ_next;
            disp_cnt_reg  <= disp_cnt_next;
            disp_addr_reg <= disp_addr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

endmodule
`default_nettype wire

FILE: rtl/core/deq_checker.sv
// Port-level checker for the double-ended queue core, bound into double_ended_queue_core.
// Depends on deq_pkg and double_ended_queue_core_assert.svh.
`default_nettype none
`include "double_ended_queue_core_assert.svh"
module deq_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              cmd_valid,
    input wire logic              cmd_ready,
    input wire deq_pkg::deq_cmd_t cmd,
    input wire logic              rsp_valid,
    input wire logic              rsp_ready,
    input wire deq_pkg::deq_rsp_t rsp
);

    import deq_pkg::*;

    logic cmd_known;
    logic rsp_known;

    assign cmd_known = (cmd.op == OP_DISPLAY) || (cmd.op == OP_PUSH_FRONT)
                    || (cmd.op == OP_PUSH_BACK) || (cmd.op == OP_POP_FRONT)
                    || (cmd.op == OP_POP_BACK);
    assign rsp_known = (rsp.status == ST_OK) || (rsp.status == ST_EMPTY)
                    || (rsp.status == ST_FULL);

    `DEQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "rsp word changed while stalled")
    `DEQ_ASSERT_NOW(a_status_code, rsp_valid, rsp_known, "rsp status out of range")
    `DEQ_ASSERT_NOW(a_fail_single, rsp_valid && (rsp.status != ST_OK), rsp.last && (rsp.item == '0), "failed op must be a single zero word")
    `DEQ_ASSERT_NEXT(a_cmd_answered, cmd_valid && cmd_ready && cmd_known && (cmd.op != OP_DISPLAY), rsp_valid && rsp.last, "push or pop word not answered in next cycle")

endmodule

bind double_ended_queue_core deq_checker u_deq_checker (.*);
`default_nettype wire

FILE: test/double_ended_queue_core_test.sv
// Self-checking testbench for double_ended_queue_core: directed and random push, pop and
// display words checked against an in-bench deque predictor. Depends on deq_pkg and the core.
`timescale 1ns / 100ps
module double_ended_queue_core_test;
    import deq_pkg::*;

    localparam int DEPTH        = DEPTH_DEF;
    localparam int RANDOM_WORDS = 320;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE       = 2 * DEPTH + 8;
    localparam int MAX_REPORTS  = 10;

    localparam logic [OP_W-1:0] OP_UNDEF_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_UNDEF_LAST  = 3'd7;

    typedef struct packed {
        logic     drain_first;
        deq_cmd_t word;
    } cmd_entry_t;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     cmd_valid = 1'b0;
    logic     cmd_ready;
    deq_cmd_t cmd       = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    deq_rsp_t rsp;

    cmd_entry_t cmd_backlog[$];
    deq_rsp_t   rsp_expected[$];

    logic signed [ITEM_W-1:0] deq_store [DEPTH];
    int unsigned head_slot  = 0;
    int unsigned fill_level = 0;

    int total_planned  = 0;
    int sent_count     = 0;
    int accepted_count = 0;
    int words_checked  = 0;
    int display_words  = 0;
    int full_refusals  = 0;
    int empty_hits     = 0;
    int mismatches     = 0;
    int cycles         = 0;

    double_ended_queue_core #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH_DEF)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int idle_pct(input bit for_receiver);
        int phase;
        phase = (total_planned == 0) ? 2 : (sent_count * 3) / total_planned;
        if (phase == 0)
            return for_receiver ? 46 : 6;
        else if (phase == 1)
            return for_receiver ? 6 : 46;
        return 0;
    endfunction

    task automatic queue_cmd(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                             input logic drain);
        cmd_entry_t e;
        e.drain_first = drain;
        e.word.op     = op;
        e.word.value  = value;
        cmd_backlog.push_back(e);
    endtask

    task automatic apply_deque_op(input deq_cmd_t w);
        deq_rsp_t    r;
        bit          known;
        int unsigned i;
        r       = '0;
        r.last  = 1'b1;
        known   = 1'b1;
        case (w.op)
            OP_DISPLAY:
            begin
                if (fill_level == 0)
                    r.status = ST_EMPTY;
                for (i = 0; i < fill_level; i++)
                begin
                    r.item = deq_store[(head_slot + i) % DEPTH];
                    r.last = (i + 1 == fill_level);
                    display_words++;
                    if (i + 1 < fill_level)
                        rsp_expected.push_back(r);
                end
            end
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (fill_level >= DEPTH)
                    r.status = ST_FULL;
                else if (w.op == OP_PUSH_FRONT)
                begin
                    head_slot = (head_slot + DEPTH - 1) % DEPTH;
                    deq_store[head_slot] = w.value;
                    fill_level++;
                end
                else
                begin
                    deq_store[(head_slot + fill_level) % DEPTH] = w.value;
                    fill_level++;
                end
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                if (fill_level == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    if (w.op == OP_POP_FRONT)
                        head_slot = (head_slot + 1) % DEPTH;
                    fill_level--;
                end
            end
            default:
                known = 1'b0;
        endcase
        if (known)
        begin
            if (r.status == ST_FULL)
                full_refusals++;
            if (r.status == ST_EMPTY)
                empty_hits++;
            rsp_expected.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    always @(posedge clk)
    begin : driver
        if (!rst_n)
            cmd_valid <= 1'b0;
        else
        begin
            if (cmd_valid && cmd_ready)
            begin
                apply_deque_op(cmd);
                accepted_count++;
            end
            if (!cmd_valid || cmd_ready)
            begin
                if (cmd_backlog.size() != 0
                    && !(cmd_backlog[0].drain_first && rsp_expected.size() != 0)
                    && $urandom_range(0, 99) >= idle_pct(1'b0))
                begin
                    cmd       <= cmd_backlog[0].word;
                    cmd_valid <= 1'b1;
                    cmd_backlog.pop_front();
                    sent_count++;
                end
                else
                    cmd_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        deq_rsp_t want;
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
        begin
            rsp_ready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
            if (rsp_valid && rsp_ready)
            begin
                words_checked++;
                if (rsp_expected.size() == 0)
                    report_mismatch($sformatf("unexpected word status=%0d item=%0d last=%0d",
                                              rsp.status, rsp.item, rsp.last));
                else
                begin
                    want = rsp_expected.pop_front();
                    if (rsp.status !== want.status || rsp.item !== want.item
                        || rsp.last !== want.last)
                        report_mismatch($sformatf(
                            "expected status=%0d item=%0d last=%0d, got status=%0d item=%0d last=%0d",
                            want.status, want.item, want.last, rsp.status, rsp.item, rsp.last));
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycles, rsp_expected.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin : stimulus
        int k;
        int mode;
        int pick;
        int push_pct;
        int planned;
        logic [OP_W-1:0] op;

        queue_cmd(OP_DISPLAY, $urandom, 1'b0);
        queue_cmd(OP_POP_FRONT, $urandom, 1'b0);
        queue_cmd(OP_POP_BACK, $urandom, 1'b0);
        for (k = OP_UNDEF_FIRST; k <= OP_UNDEF_LAST; k++)
            queue_cmd(OP_W'(k), $urandom, 1'b0);
        queue_cmd(OP_PUSH_FRONT, 32'h8000_0000, 1'b0);
        queue_cmd(OP_PUSH_BACK, 32'h7FFF_FFFF, 1'b0);
        queue_cmd(OP_PUSH_FRONT, 32'h0000_0000, 1'b0);
        queue_cmd(OP_PUSH_BACK, 32'hFFFF_FFFF, 1'b0);
        queue_cmd(OP_POP_FRONT, $urandom, 1'b0);
        queue_cmd(OP_POP_BACK, $urandom, 1'b0);
        for (k = 2; k < DEPTH; k++)
            queue_cmd(k[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, $urandom, 1'b0);
        queue_cmd(OP_PUSH_FRONT, $urandom, 1'b0);
        queue_cmd(OP_PUSH_BACK, $urandom, 1'b0);
        queue_cmd(OP_DISPLAY, $urandom, 1'b1);

        planned  = 0;
        mode     = 0;
        push_pct = 50;
        while (planned < RANDOM_WORDS)
        begin
            if (planned % 16 == 0)
            begin
                mode     = $urandom_range(0, 2);
                push_pct = (mode == 0) ? 75 : (mode == 1) ? 25 : 50;
            end
            pick = $urandom_range(0, 99);
            if (pick < 3)
                queue_cmd(OP_W'($urandom_range(OP_UNDEF_FIRST, OP_UNDEF_LAST)), $urandom,
                          1'b0);
            else
            begin
                if (pick < 12)
                    op = OP_DISPLAY;
                else if ($urandom_range(0, 99) < push_pct)
                    op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
                else
                    op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
                queue_cmd(op, $urandom, planned == RANDOM_WORDS / 2);
                planned++;
            end
        end
        total_planned = cmd_backlog.size();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || cmd_valid)
            @(posedge clk);
        while (rsp_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("%0d commands accepted, %0d result words checked, %0d display words",
                 accepted_count, words_checked, display_words);
        $display("%0d pushes refused on a full queue, %0d empty-queue results, %0d mismatches",
                 full_refusals, empty_hits, mismatches);
        if (mismatches == 0 && rsp_expected.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
